// File: hdl/segmented_deque_engine_unit_assert.svh
// Assertion macros for the bound checker in hdl/sdq_checker.sv.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef SEGMENTED_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define SEGMENTED_DEQUE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SDQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SDQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication with a delay given by the argument n.
`define SDQ_ASSERT_AFTER(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// File: hdl/sdq_pkg.sv
package sdq_pkg;

	// Geometry. Both counts are powers of two so that ring and slot arithmetic wraps
	// by truncation and an element address is the block index above the slot index.
	localparam int NUM_BLOCKS  = 16;
	localparam int BLOCK_SLOTS = 16;
	localparam int DATA_WIDTH  = 32;

	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int SLOT_W      = $clog2(BLOCK_SLOTS);
	localparam int FILL_W      = $clog2(BLOCK_SLOTS + 1);
	localparam int USED_W      = $clog2(NUM_BLOCKS + 1);
	localparam int STORE_DEPTH = NUM_BLOCKS * BLOCK_SLOTS;
	localparam int ADDR_W      = BLK_W + SLOT_W;

	// Field widths of the request and response.
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(BLOCK_SLOTS - 1);

	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ_AT    = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] last;
		logic [FILL_W-1:0] fill;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	// Everything one operation changes, as worked out in the execute cycle.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                rd_ok;
		logic [BLK_W-1:0]    head;
		logic [BLK_W-1:0]    tail;
		logic [USED_W-1:0]   used;
		logic [COUNT_W-1:0]  count;
		logic                clear_all;
		logic                desc_we;
		logic [BLK_W-1:0]    desc_addr;
		desc_t               desc;
		logic                elem_we;
		logic                elem_re;
		logic [ADDR_W-1:0]   elem_addr;
	} upd_t;

endpackage

// File: hdl/sdq_if.sv
interface sdq_req_if;
	import sdq_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [VALUE_W-1:0]  push_value;
	logic [POS_W-1:0]    position;

	modport source (output valid, output opcode, output push_value, output position,
		input ready);
	modport sink (input valid, input opcode, input push_value, input position,
		output ready);
endinterface

interface sdq_rsp_if;
	import sdq_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  element_total;

	modport source (output valid, output read_data, output status, output element_total,
		input ready);
	modport sink (input valid, input read_data, input status, input element_total,
		output ready);
endinterface

// File: hdl/segmented_deque_engine_unit.sv
// Channel  Modport  Payload                                Accepted when
// req      sink     opcode, push_value, position           req.valid && req.ready
// rsp      source   read_data, status, element_total       rsp.valid && rsp.ready
//
// For each request, the block descriptor at the ring end it needs is read
// from the descriptor memory in the accept cycle, and in the execute cycle the new
// descriptor and pointers are written back while the element memory is written or read.
// A new request is taken in the cycle its predecessor's result moves to the output
// register, so no new request is taken while its predecessor executes.
// Reset clears the ring pointers, counts and the per-block descriptor valid bits at once;
// the element memory keeps its contents and needs no clearing pass.
// When the output register is held by a stalled sink, the finished result waits and no
// new request is accepted until the register frees up.
module segmented_deque_engine_unit (
	input  logic       clk,
	input  logic       arst_n,
	sdq_req_if.sink    req,
	sdq_rsp_if.source  rsp
);
	import sdq_pkg::*;

	// The sequencer is one-hot: idle, execute, and done (result waiting to move out).
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// Ring state. Descriptors live in a small memory; a block whose valid bit is low
	// has never been written since reset or clear and reads as an all-zero descriptor.
	logic [BLK_W-1:0]      ring_head_q;
	logic [BLK_W-1:0]      ring_tail_q;
	logic [USED_W-1:0]     blocks_used_q;
	logic [COUNT_W-1:0]    element_count_q;
	logic [NUM_BLOCKS-1:0] desc_valid_q;

	// Request held through execution.
	logic [OPCODE_W-1:0]   op_s1;
	logic [VALUE_W-1:0]    value_s1;
	logic [POS_W-1:0]      pos_s1;
	logic                  desc_vld_s1;

	// Outcome of execution, waiting for the element read to return.
	logic [STATUS_W-1:0]   status_s2;
	logic                  rd_ok_s2;

	// Output register.
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_data_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [COUNT_W-1:0]    out_total_q;

	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	logic                  in_exec;
	logic [BLK_W-1:0]      rd_blk;
	logic [DESC_W-1:0]     desc_rdata;
	desc_t                 desc_cur;
	upd_t                  upd;
	logic [DATA_WIDTH-1:0] elem_rdata;

	assign out_free  = !out_valid_q || rsp.ready;
	assign in_exec   = (state_q == S_EXEC);
	assign load_out  = (state_q == S_DONE) && out_free;
	assign req.ready = (state_q == S_IDLE) || load_out;
	assign accept    = req.valid && req.ready;

	// Back-end operations work on the tail block, everything else on the head block.
	assign rd_blk = (req.opcode inside {OP_PUSH_BACK, OP_POP_BACK}) ? ring_tail_q : ring_head_q;

	sdq_ram #(
		.WIDTH (DESC_W),
		.DEPTH (NUM_BLOCKS)
	) u_desc_ram (
		.clk   (clk),
		.we    (in_exec && upd.desc_we),
		.waddr (upd.desc_addr),
		.wdata (upd.desc),
		.re    (accept),
		.raddr (rd_blk),
		.rdata (desc_rdata)
	);

	assign desc_cur = desc_vld_s1 ? desc_t'(desc_rdata) : '0;

	sdq_exec u_exec (
		.op    (op_s1),
		.pos   (pos_s1),
		.desc  (desc_cur),
		.head  (ring_head_q),
		.tail  (ring_tail_q),
		.used  (blocks_used_q),
		.count (element_count_q),
		.upd   (upd)
	);

	// Element store: written by pushes and read by read-at, both in the execute cycle.
	// The read data stays in the RAM's output register until the next read.
	sdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_elem_ram (
		.clk   (clk),
		.we    (in_exec && upd.elem_we),
		.waddr (upd.elem_addr),
		.wdata (value_s1[DATA_WIDTH-1:0]),
		.re    (in_exec && upd.elem_re),
		.raddr (upd.elem_addr),
		.rdata (elem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			ring_head_q     <= '0;
			ring_tail_q     <= '0;
			blocks_used_q   <= '0;
			element_count_q <= '0;
			desc_valid_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					ring_head_q     <= upd.head;
					ring_tail_q     <= upd.tail;
					blocks_used_q   <= upd.used;
					element_count_q <= upd.count;
					if (upd.clear_all) begin
						desc_valid_q <= '0;
					end else if (upd.desc_we) begin
						desc_valid_q[upd.desc_addr] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= accept ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.opcode;
			value_s1    <= req.push_value;
			pos_s1      <= req.position;
			desc_vld_s1 <= desc_valid_q[rd_blk];
		end
		if (in_exec) begin
			status_s2 <= upd.status;
			rd_ok_s2  <= upd.rd_ok;
		end
		if (load_out) begin
			out_data_q   <= rd_ok_s2 ? VALUE_W'(elem_rdata) : '0;
			out_status_q <= status_s2;
			out_total_q  <= element_count_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = out_data_q;
	assign rsp.status        = out_status_q;
	assign rsp.element_total = out_total_q;
endmodule

// File: hdl/sdq_ram.sv
module sdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hdl/sdq_exec.sv
module sdq_exec (
	input  logic [sdq_pkg::OPCODE_W-1:0] op,
	input  logic [sdq_pkg::POS_W-1:0]    pos,
	input  sdq_pkg::desc_t               desc,
	input  logic [sdq_pkg::BLK_W-1:0]    head,
	input  logic [sdq_pkg::BLK_W-1:0]    tail,
	input  logic [sdq_pkg::USED_W-1:0]   used,
	input  logic [sdq_pkg::COUNT_W-1:0]  count,
	output sdq_pkg::upd_t                upd
);
	import sdq_pkg::*;

	logic              open_new;
	logic              ring_full;
	logic              is_empty;
	logic [BLK_W-1:0]  blk;
	logic [SLOT_W-1:0] slot;
	logic [POS_W-1:0]  rest;

	assign ring_full = (used == USED_W'(NUM_BLOCKS));
	assign is_empty  = (count == '0) || (used == '0);
	assign rest      = POS_W'(pos - POS_W'(desc.fill));

	always_comb begin
		upd           = '0;
		upd.status    = ST_OK;
		upd.head      = head;
		upd.tail      = tail;
		upd.used      = used;
		upd.count     = count;
		upd.desc_addr = tail;
		open_new      = 1'b0;
		blk           = tail;
		slot          = '0;

		case (op)
			OP_PUSH_BACK: begin
				open_new = (used == '0) || (desc.last == SLOT_MAX);
				if (open_new && ring_full) begin
					upd.status = ST_FULL;
				end else begin
					blk  = open_new ? ((used != '0) ? BLK_W'(tail + 1'b1) : head) : tail;
					slot = open_new ? '0 : SLOT_W'(desc.last + 1'b1);
					upd.tail       = blk;
					upd.used       = USED_W'(used + open_new);
					upd.count      = COUNT_W'(count + 1'b1);
					upd.desc_we    = 1'b1;
					upd.desc_addr  = blk;
					upd.desc.first = open_new ? '0 : desc.first;
					upd.desc.last  = slot;
					upd.desc.fill  = open_new ? FILL_W'(1) : FILL_W'(desc.fill + 1'b1);
					upd.elem_we    = 1'b1;
					upd.elem_addr  = {blk, slot};
				end
			end
			OP_PUSH_FRONT: begin
				open_new = (used == '0) || ((desc.fill != '0) && (desc.first == '0));
				if (open_new && ring_full) begin
					upd.status = ST_FULL;
				end else begin
					blk  = open_new ? ((used != '0) ? BLK_W'(head - 1'b1) : tail) : head;
					slot = open_new ? SLOT_MAX : SLOT_W'(desc.first - 1'b1);
					upd.head       = blk;
					upd.used       = USED_W'(used + open_new);
					upd.count      = COUNT_W'(count + 1'b1);
					upd.desc_we    = 1'b1;
					upd.desc_addr  = blk;
					upd.desc.first = slot;
					upd.desc.last  = open_new ? SLOT_MAX : desc.last;
					upd.desc.fill  = open_new ? FILL_W'(1) : FILL_W'(desc.fill + 1'b1);
					upd.elem_we    = 1'b1;
					upd.elem_addr  = {blk, slot};
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					upd.status = ST_EMPTY;
				end else begin
					upd.count     = COUNT_W'(count - 1'b1);
					upd.desc_we   = 1'b1;
					upd.desc_addr = tail;
					if (desc.fill <= FILL_W'(1)) begin
						// The end block empties: release it and step the tail back.
						upd.desc = '0;
						upd.tail = (used != USED_W'(1)) ? BLK_W'(tail - 1'b1) : head;
						upd.used = USED_W'(used - 1'b1);
					end else begin
						upd.desc.first = desc.first;
						upd.desc.last  = SLOT_W'(desc.last - 1'b1);
						upd.desc.fill  = FILL_W'(desc.fill - 1'b1);
					end
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					upd.status = ST_EMPTY;
				end else begin
					upd.count     = COUNT_W'(count - 1'b1);
					upd.desc_we   = 1'b1;
					upd.desc_addr = head;
					if (desc.fill <= FILL_W'(1)) begin
						upd.desc = '0;
						upd.head = (used != USED_W'(1)) ? BLK_W'(head + 1'b1) : tail;
						upd.used = USED_W'(used - 1'b1);
					end else begin
						upd.desc.first = SLOT_W'(desc.first + 1'b1);
						upd.desc.last  = desc.last;
						upd.desc.fill  = FILL_W'(desc.fill - 1'b1);
					end
				end
			end
			OP_READ_AT: begin
				if (COUNT_W'(pos) >= count) begin
					upd.status = ST_RANGE;
				end else begin
					// Inside the head block the slot is offset from its first slot;
					// past it, the blocks that follow are counted from slot zero.
					if (COUNT_W'(pos) < COUNT_W'(desc.fill)) begin
						blk  = head;
						slot = SLOT_W'(desc.first + SLOT_W'(pos));
					end else begin
						blk  = BLK_W'(head + BLK_W'(rest >> SLOT_W) + 1'b1);
						slot = SLOT_W'(rest);
					end
					upd.rd_ok     = 1'b1;
					upd.elem_re   = 1'b1;
					upd.elem_addr = {blk, slot};
				end
			end
			OP_CLEAR: begin
				upd.clear_all = 1'b1;
				upd.head      = '0;
				upd.tail      = '0;
				upd.used      = '0;
				upd.count     = '0;
			end
			default: begin
			end
		endcase
	end
endmodule

// File: hdl/sdq_checker.sv
`include "segmented_deque_engine_unit_assert.svh"

module sdq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [sdq_pkg::VALUE_W-1:0]  rsp_read_data,
	input logic [sdq_pkg::STATUS_W-1:0] rsp_status,
	input logic [sdq_pkg::COUNT_W-1:0]  rsp_total
);
	import sdq_pkg::*;

	// Requests are never taken back to back.
	`SDQ_ASSERT_NXT(a_req_spacing, req_valid && req_ready, !req_ready, "request taken twice in a row")

	// Once a request is taken, a response is offered when that request has passed the execute and done states.
	`SDQ_ASSERT_AFTER(a_rsp_latency, req_valid && req_ready, 3, rsp_valid, "response missing after request")

	// A stalled response stays offered.
	`SDQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	// A refused pop only happens on an empty deque.
	`SDQ_ASSERT_IMP(a_empty_total, rsp_valid && rsp_status == ST_EMPTY, rsp_total == '0, "empty status with elements held")

	// Data is only returned with a good status.
	`SDQ_ASSERT_IMP(a_data_zero, rsp_valid && rsp_status != ST_OK, rsp_read_data == '0, "data on refused request")
endmodule

bind segmented_deque_engine_unit sdq_checker u_sdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_status    (rsp.status),
	.rsp_total     (rsp.element_total)
);

// File: sim/sdq_deque_checker.sv
module sdq_deque_checker (
	input  logic clk,
	input  logic arst_n,
	sdq_req_if   req,
	sdq_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   checked,
	output int   refused_full,
	output int   refused_empty,
	output int   out_of_range,
	output int   reads_ok,
	output int   peak_total
);
	import sdq_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  element_total;
	} deque_result_t;

	// Shadow of the deque: element store, block descriptors and ring pointers.
	logic [DATA_WIDTH-1:0] shadow_store [STORE_DEPTH];
	desc_t                 ring_desc [NUM_BLOCKS];
	logic [BLK_W-1:0]      front_blk;
	logic [BLK_W-1:0]      back_blk;
	logic [USED_W-1:0]     live_blocks;
	logic [COUNT_W-1:0]    held;

	deque_result_t pending_results [$];
	deque_result_t want;
	deque_result_t got;

	function void reset_ring();
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			ring_desc[b] = '0;
		end
		front_blk   = '0;
		back_blk    = '0;
		live_blocks = '0;
		held        = '0;
	endfunction

	function deque_result_t apply_deque_op(input logic [OPCODE_W-1:0] op,
		input logic [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		deque_result_t     r;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  blk;
		int                rest;
		r = '0;
		r.status = ST_OK;
		slot = '0;
		blk = '0;
		case (op)
			OP_PUSH_BACK: begin
				if (live_blocks != 0 && ring_desc[back_blk].last != SLOT_MAX) begin
					slot = ring_desc[back_blk].last + 1'b1;
				end else if (live_blocks < NUM_BLOCKS) begin
					if (live_blocks != 0) begin
						back_blk = back_blk + 1'b1;
					end else begin
						back_blk = front_blk;
					end
					live_blocks = live_blocks + 1'b1;
					slot = '0;
					ring_desc[back_blk].first = '0;
					ring_desc[back_blk].fill = '0;
				end else begin
					r.status = ST_FULL;
				end
				if (r.status == ST_OK) begin
					shadow_store[{back_blk, slot}] = value[DATA_WIDTH-1:0];
					ring_desc[back_blk].last = slot;
					ring_desc[back_blk].fill = ring_desc[back_blk].fill + 1'b1;
					held = held + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (live_blocks != 0 && !(ring_desc[front_blk].fill != 0 &&
					ring_desc[front_blk].first == 0)) begin
					slot = ring_desc[front_blk].first - 1'b1;
				end else if (live_blocks < NUM_BLOCKS) begin
					if (live_blocks != 0) begin
						front_blk = front_blk - 1'b1;
					end else begin
						front_blk = back_blk;
					end
					live_blocks = live_blocks + 1'b1;
					slot = SLOT_MAX;
					ring_desc[front_blk].last = SLOT_MAX;
					ring_desc[front_blk].fill = '0;
				end else begin
					r.status = ST_FULL;
				end
				if (r.status == ST_OK) begin
					shadow_store[{front_blk, slot}] = value[DATA_WIDTH-1:0];
					ring_desc[front_blk].first = slot;
					ring_desc[front_blk].fill = ring_desc[front_blk].fill + 1'b1;
					held = held + 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (held == 0 || live_blocks == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (ring_desc[back_blk].fill <= 1) begin
						ring_desc[back_blk] = '0;
						if (live_blocks != 1) begin
							back_blk = back_blk - 1'b1;
						end else begin
							back_blk = front_blk;
						end
						live_blocks = live_blocks - 1'b1;
					end else begin
						ring_desc[back_blk].last = ring_desc[back_blk].last - 1'b1;
						ring_desc[back_blk].fill = ring_desc[back_blk].fill - 1'b1;
					end
					held = held - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (held == 0 || live_blocks == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (ring_desc[front_blk].fill <= 1) begin
						ring_desc[front_blk] = '0;
						if (live_blocks != 1) begin
							front_blk = front_blk + 1'b1;
						end else begin
							front_blk = back_blk;
						end
						live_blocks = live_blocks - 1'b1;
					end else begin
						ring_desc[front_blk].first = ring_desc[front_blk].first + 1'b1;
						ring_desc[front_blk].fill = ring_desc[front_blk].fill - 1'b1;
					end
					held = held - 1'b1;
				end
			end
			OP_READ_AT: begin
				if ({1'b0, pos} >= held) begin
					r.status = ST_RANGE;
				end else begin
					// Inside the front block the slot is relative to its first slot;
					// past it the blocks are taken as full and counted from slot zero.
					if (pos < ring_desc[front_blk].fill) begin
						blk = front_blk;
						slot = ring_desc[front_blk].first + pos[SLOT_W-1:0];
					end else begin
						rest = int'(pos) - int'(ring_desc[front_blk].fill);
						blk = BLK_W'(int'(front_blk) + rest / BLOCK_SLOTS + 1);
						slot = SLOT_W'(rest % BLOCK_SLOTS);
					end
					r.read_data = VALUE_W'(shadow_store[{blk, slot}]);
				end
			end
			OP_CLEAR: begin
				reset_ring();
			end
			default: begin
			end
		endcase
		r.element_total = held;
		return r;
	endfunction

	task report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at response %0d (%s): expected data %h status %0d total %0d",
				checked, what, want.read_data, want.status, want.element_total);
			$display("    got data %h status %0d total %0d",
				rsp.read_data, rsp.status, rsp.element_total);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_ring();
			pending_results.delete();
			outstanding   = 0;
			checked       = 0;
			refused_full  = 0;
			refused_empty = 0;
			out_of_range  = 0;
			reads_ok      = 0;
			peak_total    = 0;
		end else begin
			// Responses are compared before the request of this edge is predicted, so a
			// response always meets the expectations of strictly older requests.
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (pending_results.size() == 0) begin
					want = '0;
					report_mismatch("no request waiting");
				end else begin
					want = pending_results.pop_front();
					if (rsp.read_data !== want.read_data || rsp.status !== want.status ||
						rsp.element_total !== want.element_total) begin
						report_mismatch("field differs");
					end
				end
			end
			if (req.valid && req.ready) begin
				got = apply_deque_op(req.opcode, req.push_value, req.position);
				pending_results.push_back(got);
				case (got.status)
					ST_FULL:  refused_full++;
					ST_EMPTY: refused_empty++;
					ST_RANGE: out_of_range++;
					default: begin
						if (req.opcode == OP_READ_AT) begin
							reads_ok++;
						end
					end
				endcase
				if (int'(got.element_total) > peak_total) begin
					peak_total = int'(got.element_total);
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// File: sim/tb_segmented_deque_engine_unit.sv
// Stimulus and verdict for the segmented deque engine. The checker instance next to the
// block watches both channels, keeps its own copy of the deque and compares every
// response; this module only produces requests, drives the response ready and decides
// pass or fail from the checker's counters.
module tb_segmented_deque_engine_unit;
	import sdq_pkg::*;

	localparam int RANDOM_ITEMS    = 1150;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int PRESSURE_AT     = 900;
	localparam int PRESSURE_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 20;

	// The opcode field is three bits wide; the two codes above clear are no-ops.
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

	typedef enum int {RUN_GROW, RUN_SHRINK, RUN_MIXED, RUN_FLOOD, RUN_DRAIN} run_kind_t;

	logic clk;
	logic arst_n;
	logic hold_rsp;
	logic [COUNT_W-1:0] last_total = '0;

	int cycles        = 0;
	int requests_sent = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 79;

	int mismatches;
	int outstanding;
	int checked;
	int refused_full;
	int refused_empty;
	int out_of_range;
	int reads_ok;
	int peak_total;

	sdq_req_if req();
	sdq_rsp_if rsp();

	segmented_deque_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sdq_deque_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.checked       (checked),
		.refused_full  (refused_full),
		.refused_empty (refused_empty),
		.out_of_range  (out_of_range),
		.reads_ok      (reads_ok),
		.peak_total    (peak_total)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_segmented_deque_engine_unit: FAIL");
			$finish;
		end
	end

	// The last reported fill level steers read positions toward held elements.
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			last_total <= rsp.element_total;
		end
	end

	// Response ready: random stalls at the current idle rate, and nothing at all while
	// the long hold-off is active.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Once, late in the run where the sender never idles, the receiver stops for a long
	// stretch. The output register fills, the block stops taking requests, and the
	// sender keeps its request on the channel the whole time.
	initial begin
		hold_rsp = 1'b0;
		wait (requests_sent >= PRESSURE_AT);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// Offers one request and returns at the edge where it is accepted. Valid stays high
	// into the next call unless that call starts with an idle gap, so valid never gets
	// two assignments in one time step.
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value,
		input logic [POS_W-1:0] pos);
		if (requests_sent < RANDOM_ITEMS / 3) begin
			send_idle_pct = 24;
			recv_idle_pct = 79;
		end else if (requests_sent < 2 * RANDOM_ITEMS / 3) begin
			send_idle_pct = 79;
			recv_idle_pct = 24;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= op;
		req.push_value <= value;
		req.position   <= pos;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		requests_sent++;
	endtask

	// Read positions mostly fall inside the held range, with a few just past its end
	// and a few anywhere in the field.
	function automatic logic [POS_W-1:0] pick_position();
		int p;
		if ($urandom_range(9) == 0) begin
			return POS_W'($urandom_range(255));
		end
		p = $urandom_range(int'(last_total));
		return (p > 255) ? POS_W'(255) : POS_W'(p);
	endfunction

	// Operation mix per kind of run: growth runs push the deque toward full, shrink
	// and drain runs take it back to empty, mixed runs read a lot and clear now and then.
	function automatic logic [OPCODE_W-1:0] pick_op(input run_kind_t kind);
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(199);
		if (roll < 3) begin
			return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
		end
		if (roll < 6 && (kind == RUN_MIXED || kind == RUN_SHRINK)) begin
			return OP_CLEAR;
		end
		case (kind)
			RUN_GROW: begin
				push_pct = 70;
				pop_pct  = 15;
			end
			RUN_SHRINK: begin
				push_pct = 15;
				pop_pct  = 70;
			end
			RUN_FLOOD: begin
				push_pct = 90;
				pop_pct  = 5;
			end
			RUN_DRAIN: begin
				push_pct = 5;
				pop_pct  = 90;
			end
			default: begin
				push_pct = 35;
				pop_pct  = 35;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < push_pct) begin
			return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		end
		if (roll < push_pct + pop_pct) begin
			return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
		end
		return OP_READ_AT;
	endfunction

	initial begin
		int                  issued;
		int                  run_len;
		int                  roll;
		run_kind_t           kind;
		logic [OPCODE_W-1:0] op;

		req.valid      = 1'b0;
		req.opcode     = OP_PUSH_BACK;
		req.push_value = '0;
		req.position   = '0;
		arst_n         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every good read here lands on a slot written just before, since the
		// element store has no reset. It covers the refusals on an empty deque, a read
		// past the end, the first push from either side, a release of the last block
		// (the moving end snaps back), clear, and the two spare opcodes.
		send_request(OP_READ_AT, '0, '0);
		send_request(OP_POP_BACK, '0, '0);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_READ_AT, '0, 8'hff);
		send_request(OP_SPARE_LO, 32'hffff_ffff, 8'hff);
		send_request(OP_SPARE_HI, 32'hffff_ffff, 8'hff);
		send_request(OP_PUSH_FRONT, 32'hffff_ffff, '0);
		send_request(OP_READ_AT, '0, 8'd0);
		send_request(OP_PUSH_BACK, 32'h0000_0000, '0);
		send_request(OP_READ_AT, '0, 8'd1);
		send_request(OP_READ_AT, '0, 8'd2);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_POP_BACK, '0, '0);
		send_request(OP_PUSH_BACK, 32'ha5a5_a5a5, '0);
		send_request(OP_PUSH_BACK, 32'h5a5a_5a5a, '0);
		send_request(OP_READ_AT, '0, 8'd1);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_PUSH_FRONT, 32'h0000_0001, '0);
		send_request(OP_PUSH_FRONT, 32'h8000_0000, '0);
		send_request(OP_READ_AT, '0, 8'd0);
		send_request(OP_READ_AT, '0, 8'd1);
		send_request(OP_POP_BACK, '0, '0);
		send_request(OP_CLEAR, '0, '0);

		// Fill the whole ring from the back. This writes every entry of the element
		// store, so later reads may land anywhere, and it reaches the full state where
		// pushes at both ends are refused.
		for (int i = 0; i < STORE_DEPTH; i++) begin
			send_request(OP_PUSH_BACK, $urandom(), POS_W'($urandom_range(255)));
		end
		send_request(OP_PUSH_BACK, $urandom(), '0);
		send_request(OP_PUSH_FRONT, $urandom(), '0);
		send_request(OP_READ_AT, '0, 8'hff);
		send_request(OP_READ_AT, '0, 8'd0);
		send_request(OP_READ_AT, '0, POS_W'(STORE_DEPTH / 2));
		issued = STORE_DEPTH + 5;

		// Random runs of growth, shrinkage and mixed traffic with random content. The
		// long flood and drain runs drive the ring around and into both refusals.
		while (issued < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				kind = RUN_GROW;
			end else if (roll < 58) begin
				kind = RUN_SHRINK;
			end else if (roll < 90) begin
				kind = RUN_MIXED;
			end else if (roll < 95) begin
				kind = RUN_FLOOD;
			end else begin
				kind = RUN_DRAIN;
			end
			if (kind == RUN_FLOOD || kind == RUN_DRAIN) begin
				run_len = $urandom_range(150, 280);
			end else begin
				run_len = $urandom_range(10, 60);
			end
			for (int k = 0; k < run_len && issued < RANDOM_ITEMS; k++) begin
				op = pick_op(kind);
				send_request(op, $urandom(),
					(op == OP_READ_AT) ? pick_position() : POS_W'($urandom_range(255)));
				if (op != OP_SPARE_LO && op != OP_SPARE_HI) begin
					issued++;
				end
			end
		end

		req.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d responses checked, peak fill %0d of %0d elements",
			requests_sent, checked, peak_total, STORE_DEPTH);
		$display("refusals: %0d full, %0d empty, %0d out of range; %0d good reads",
			refused_full, refused_empty, out_of_range, reads_ok);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_segmented_deque_engine_unit: PASS");
		end else begin
			$display("tb_segmented_deque_engine_unit: FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/sdq_pkg.sv
hdl/sdq_if.sv
hdl/sdq_ram.sv
hdl/sdq_exec.sv
hdl/segmented_deque_engine_unit.sv
hdl/sdq_checker.sv
sim/sdq_deque_checker.sv
sim/tb_segmented_deque_engine_unit.sv
